[rtl/hwt_pkg.sv]
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared constants, codes and controller/datapath handshake types for the
// hierarchical timer wheel.
// ----------------------------------------------------------------------------
package hwt_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam int NEAR_BITS_DEF  = 8;
    localparam int LEVEL_BITS_DEF = 6;

    localparam int LINK_W = 6;
    localparam logic [LINK_W-1:0] EMPTY_MARK = 6'd63;

    // request codes
    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_KILL = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // event codes
    localparam logic [2:0] EVT_ADD_OK    = 3'd0;
    localparam logic [2:0] EVT_ADD_BUSY  = 3'd1;
    localparam logic [2:0] EVT_KILL_OK   = 3'd2;
    localparam logic [2:0] EVT_KILL_NA   = 3'd3;
    localparam logic [2:0] EVT_EXPIRED   = 3'd4;
    localparam logic [2:0] EVT_TICK_DONE = 3'd5;

    typedef struct packed {
        logic clr;
        logic latch;
        logic dispatch;
        logic cas_det;
        logic load_head;
        logic cas_get;
        logic load_nx;
        logic lvl_inc;
        logic near_det;
        logic set_done;
        logic near_get;
        logic free_slot;
        logic pl0;
        logic pl1;
        logic pl2;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       in_valid;
        logic [1:0] req_type;
        logic       req_bad;
        logic       near_zero;
        logic       head_ok;
        logic       nx_ok;
        logic       lvl_end;
        logic       killed;
        logic       per_nz;
        logic       out_free;
    } t_sts;

endpackage

[rtl/hwt_req_if.sv]
// ----------------------------------------------------------------------------
// hwt_req_if
// Request channel: valid/ready with the request payload.
// ----------------------------------------------------------------------------
interface hwt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [4:0]  timer_id;
    logic [31:0] delay;
    logic [31:0] period;

    modport source (output valid, req_type, timer_id, delay, period, input ready);
    modport sink   (input valid, req_type, timer_id, delay, period, output ready);
endinterface

[rtl/hwt_evt_if.sv]
// ----------------------------------------------------------------------------
// hwt_evt_if
// Event channel: valid/ready with the event payload.
// ----------------------------------------------------------------------------
interface hwt_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [4:0]  timer_id_out;
    logic [31:0] tick_value;
    logic        last;

    modport source (output valid, event_kind, timer_id_out, tick_value, last, input ready);
    modport sink   (input valid, event_kind, timer_id_out, tick_value, last, output ready);
endinterface

[rtl/hwt_ram.sv]
// ----------------------------------------------------------------------------
// hwt_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module hwt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/hwt_ctrl.sv]
// ----------------------------------------------------------------------------
// hwt_ctrl
// Sequencer: clearing pass, request dispatch, cascade and near-bucket walks,
// and the shared placement routine.
// ----------------------------------------------------------------------------
module hwt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hwt_pkg::t_sts i_sts,
    output hwt_pkg::t_cmd o_cmd
);
    typedef enum logic [19:0] {
        S_CLR      = 20'h00001,
        S_IDLE     = 20'h00002,
        S_DISP     = 20'h00004,
        S_EMIT_END = 20'h00008,
        S_CAS_DET  = 20'h00010,
        S_CAS_HD   = 20'h00020,
        S_CAS_RD   = 20'h00040,
        S_CAS_GET  = 20'h00080,
        S_CAS_ADV  = 20'h00100,
        S_CAS_NXT  = 20'h00200,
        S_NEAR_DET = 20'h00400,
        S_NEAR_HD  = 20'h00800,
        S_NEAR_RD  = 20'h01000,
        S_NEAR_GET = 20'h02000,
        S_EMIT_EXP = 20'h04000,
        S_NEAR_RE  = 20'h08000,
        S_NEAR_ADV = 20'h10000,
        S_PL0      = 20'h20000,
        S_PL1      = 20'h40000,
        S_PL2      = 20'h80000
    } t_state;

    t_state r_state, n_state;
    t_state r_pret, n_pret;   // return point of the placement routine

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_pret  <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_pret  <= n_pret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pret  = r_pret;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.latch = 1'b1;
                if (i_sts.in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                o_cmd.dispatch = 1'b1;
                case (i_sts.req_type)
                    hwt_pkg::REQ_ADD: begin
                        if (i_sts.req_bad) begin
                            n_state = S_EMIT_END;
                        end else begin
                            n_state = S_PL0;
                            n_pret  = S_EMIT_END;
                        end
                    end
                    hwt_pkg::REQ_KILL: n_state = S_EMIT_END;
                    hwt_pkg::REQ_TICK: n_state = i_sts.near_zero ? S_CAS_DET : S_NEAR_DET;
                    default:           n_state = S_IDLE;
                endcase
            end
            S_EMIT_END: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_CAS_DET: begin
                o_cmd.cas_det = 1'b1;
                n_state = S_CAS_HD;
            end
            S_CAS_HD: begin
                o_cmd.load_head = 1'b1;
                n_state = i_sts.head_ok ? S_CAS_RD : S_CAS_NXT;
            end
            S_CAS_RD: n_state = S_CAS_GET;
            S_CAS_GET: begin
                o_cmd.cas_get = 1'b1;
                n_state = S_PL0;
                n_pret  = S_CAS_ADV;
            end
            S_CAS_ADV: begin
                o_cmd.load_nx = 1'b1;
                n_state = i_sts.nx_ok ? S_CAS_RD : S_CAS_NXT;
            end
            S_CAS_NXT: begin
                o_cmd.lvl_inc = 1'b1;
                n_state = i_sts.lvl_end ? S_NEAR_DET : S_CAS_DET;
            end
            S_NEAR_DET: begin
                o_cmd.near_det = 1'b1;
                n_state = S_NEAR_HD;
            end
            S_NEAR_HD: begin
                o_cmd.load_head = 1'b1;
                if (i_sts.head_ok) begin
                    n_state = S_NEAR_RD;
                end else begin
                    o_cmd.set_done = 1'b1;
                    n_state = S_EMIT_END;
                end
            end
            S_NEAR_RD: n_state = S_NEAR_GET;
            S_NEAR_GET: begin
                o_cmd.near_get = 1'b1;
                n_state = i_sts.killed ? S_NEAR_ADV : S_EMIT_EXP;
            end
            S_EMIT_EXP: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_free) n_state = S_NEAR_RE;
            end
            S_NEAR_RE: begin
                if (i_sts.per_nz) begin
                    n_state = S_PL0;
                    n_pret  = S_NEAR_ADV;
                end else begin
                    o_cmd.free_slot = 1'b1;
                    n_state = S_NEAR_ADV;
                end
            end
            S_NEAR_ADV: begin
                o_cmd.load_nx = 1'b1;
                if (i_sts.nx_ok) begin
                    n_state = S_NEAR_RD;
                end else begin
                    o_cmd.set_done = 1'b1;
                    n_state = S_EMIT_END;
                end
            end
            S_PL0: begin
                o_cmd.pl0 = 1'b1;
                n_state = S_PL1;
            end
            S_PL1: begin
                o_cmd.pl1 = 1'b1;
                n_state = S_PL2;
            end
            S_PL2: begin
                o_cmd.pl2 = 1'b1;
                n_state = r_pret;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/hwt_datapath.sv]
// ----------------------------------------------------------------------------
// hwt_datapath
// Tick counter, slot flags, slot and bucket memories, bucket selection and
// the event output register.
// ----------------------------------------------------------------------------
module hwt_datapath #(
    parameter int NUM_TIMERS = hwt_pkg::NUM_TIMERS_DEF,
    parameter int NEAR_BITS  = hwt_pkg::NEAR_BITS_DEF,
    parameter int LEVEL_BITS = hwt_pkg::LEVEL_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hwt_req_if.sink        i_req,
    hwt_evt_if.source      o_evt,
    input  hwt_pkg::t_cmd  i_cmd,
    output hwt_pkg::t_sts  o_sts
);
    localparam int NS   = 1 << NEAR_BITS;
    localparam int LS   = 1 << LEVEL_BITS;
    localparam int NBK  = NS + 4 * LS;
    localparam int BW   = $clog2(NBK);
    localparam int SW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TOP  = NEAR_BITS + 4 * LEVEL_BITS;
    localparam logic [31:0] TOP_MAX = (TOP >= 32) ? 32'hFFFF_FFFF
                                                  : 32'((64'd1 << TOP) - 64'd1);
    localparam int LW = hwt_pkg::LINK_W;

    // latched request
    logic [1:0]  r_type;
    logic [4:0]  r_id;
    logic [31:0] r_delay, r_period;

    logic [31:0] r_tick, r_tbase, r_exp, r_dist;
    logic [NUM_TIMERS-1:0] r_alive, r_killed;
    logic [LW-1:0] r_slot, r_nx;
    logic [BW-1:0] r_bkt, r_clr;
    logic [1:0]    r_lvl;
    logic          r_pnz;

    // staged event, then output register
    logic [2:0]  r_kind;
    logic [4:0]  r_eid;
    logic        r_elast;
    logic        r_ov;
    logic [2:0]  r_okind;
    logic [4:0]  r_oid;
    logic [31:0] r_otick;
    logic        r_olast;

    // memory ports
    logic [LW-1:0] head_q, tail_q, next_q;
    logic [31:0]   exp_q, per_q;
    logic          h_we, n_we, p_we;
    logic [BW-1:0] h_ra, h_wa;
    logic [LW-1:0] h_wd, n_wd;
    logic [SW-1:0] n_wa;

    logic [LW-1:0] id6;
    logic [SW-1:0] id_ix, slot_ix;
    logic          id_ok, add_bad, kill_bad, out_free, add_go;
    logic [LEVEL_BITS-1:0] cas_idx [4];
    logic [LEVEL_BITS-1:0] lvl_idx [4];
    logic [1:0]    lvl_sel;
    logic [BW-1:0] cas_bkt, near_bkt, pl_bkt;
    logic [31:0]   exp_gap;

    assign id6      = {1'b0, r_id};
    assign id_ix    = id6[SW-1:0];
    assign slot_ix  = r_slot[SW-1:0];
    assign id_ok    = id6 < LW'(NUM_TIMERS);
    assign add_bad  = !id_ok || r_alive[id_ix];
    assign kill_bad = !id_ok || !r_alive[id_ix] || r_killed[id_ix];
    assign out_free = !r_ov || o_evt.ready;
    assign add_go   = i_cmd.dispatch && (r_type == hwt_pkg::REQ_ADD) && !add_bad;
    assign exp_gap  = r_exp - r_tick;

    // bucket selection
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            cas_idx[n] = LEVEL_BITS'(r_tbase >> (NEAR_BITS + n * LEVEL_BITS));
            lvl_idx[n] = LEVEL_BITS'(r_exp >> (NEAR_BITS + n * LEVEL_BITS));
        end
        lvl_sel = 2'd3;
        for (int n = 2; n >= 0; n--) begin
            if ((r_dist >> (NEAR_BITS + (n + 1) * LEVEL_BITS)) == 32'd0) lvl_sel = 2'(n);
        end
        cas_bkt  = BW'(NS) + (BW'(r_lvl) << LEVEL_BITS) + BW'(cas_idx[r_lvl]);
        near_bkt = BW'(r_tbase[NEAR_BITS-1:0]);
        if ((r_dist >> NEAR_BITS) == 32'd0) begin
            pl_bkt = BW'(r_exp[NEAR_BITS-1:0]);
        end else begin
            pl_bkt = BW'(NS) + (BW'(lvl_sel) << LEVEL_BITS) + BW'(lvl_idx[lvl_sel]);
        end
    end

    // memory port muxing
    always_comb begin
        h_ra = r_bkt;
        if (i_cmd.cas_det) begin
            h_ra = cas_bkt;
        end else if (i_cmd.near_det) begin
            h_ra = near_bkt;
        end else if (i_cmd.pl1) begin
            h_ra = pl_bkt;
        end
        h_we = i_cmd.clr || i_cmd.cas_det || i_cmd.near_det
               || (i_cmd.pl2 && head_q == hwt_pkg::EMPTY_MARK);
        h_wa = i_cmd.clr ? r_clr : (i_cmd.pl2 ? r_bkt : h_ra);
        h_wd = i_cmd.pl2 ? r_slot : hwt_pkg::EMPTY_MARK;
        n_we = i_cmd.pl1 || (i_cmd.pl2 && head_q != hwt_pkg::EMPTY_MARK);
        n_wa = i_cmd.pl1 ? slot_ix : tail_q[SW-1:0];
        n_wd = i_cmd.pl1 ? hwt_pkg::EMPTY_MARK : r_slot;
        p_we = add_go;
    end

    hwt_ram #(.W(LW), .D(NBK)) u_head (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(head_q)
    );
    hwt_ram #(.W(LW), .D(NBK)) u_tail (
        .i_clk(i_clk), .i_we(i_cmd.pl2), .i_waddr(r_bkt), .i_wdata(r_slot),
        .i_raddr(h_ra), .o_rdata(tail_q)
    );
    hwt_ram #(.W(LW), .D(NUM_TIMERS)) u_next (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_wa), .i_wdata(n_wd),
        .i_raddr(slot_ix), .o_rdata(next_q)
    );
    hwt_ram #(.W(32), .D(NUM_TIMERS)) u_expiry (
        .i_clk(i_clk), .i_we(i_cmd.pl1), .i_waddr(slot_ix), .i_wdata(r_exp),
        .i_raddr(slot_ix), .o_rdata(exp_q)
    );
    hwt_ram #(.W(32), .D(NUM_TIMERS)) u_period (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(id_ix), .i_wdata(r_period),
        .i_raddr(slot_ix), .o_rdata(per_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_alive  <= '0;
            r_killed <= '0;
            r_ov     <= 1'b0;
            r_clr    <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.near_det) r_tick <= r_tbase + 32'd1;
            if (i_cmd.emit && out_free) begin
                r_ov <= 1'b1;
            end else if (o_evt.ready) begin
                r_ov <= 1'b0;
            end
            if (add_go) begin
                r_alive[id_ix]  <= 1'b1;
                r_killed[id_ix] <= 1'b0;
            end
            if (i_cmd.dispatch && r_type == hwt_pkg::REQ_KILL && !kill_bad) begin
                r_killed[id_ix] <= 1'b1;
            end
            if (i_cmd.near_get && r_killed[slot_ix]) begin
                r_alive[slot_ix]  <= 1'b0;
                r_killed[slot_ix] <= 1'b0;
            end
            if (i_cmd.free_slot) r_alive[slot_ix] <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_type   <= i_req.req_type;
            r_id     <= i_req.timer_id;
            r_delay  <= i_req.delay;
            r_period <= i_req.period;
        end
        if (i_cmd.dispatch) begin
            r_tbase <= r_tick;
            r_lvl   <= 2'd0;
            r_slot  <= id6;
            r_exp   <= r_tick + ((r_delay != 32'd0) ? r_delay : r_period);
            r_eid   <= r_id;
            r_elast <= 1'b1;
            if (r_type == hwt_pkg::REQ_ADD) begin
                r_kind <= add_bad ? hwt_pkg::EVT_ADD_BUSY : hwt_pkg::EVT_ADD_OK;
            end else begin
                r_kind <= kill_bad ? hwt_pkg::EVT_KILL_NA : hwt_pkg::EVT_KILL_OK;
            end
        end
        if (i_cmd.load_head) r_slot <= head_q;
        if (i_cmd.load_nx)   r_slot <= r_nx;
        if (i_cmd.cas_get) begin
            r_nx  <= next_q;
            r_exp <= exp_q;
        end
        if (i_cmd.lvl_inc) r_lvl <= r_lvl + 2'd1;
        if (i_cmd.near_get) begin
            r_nx    <= next_q;
            r_kind  <= hwt_pkg::EVT_EXPIRED;
            r_eid   <= r_slot[4:0];
            r_elast <= 1'b0;
            r_exp   <= r_tbase + per_q;
            r_pnz   <= per_q != 32'd0;
        end
        if (i_cmd.set_done) begin
            r_kind  <= hwt_pkg::EVT_TICK_DONE;
            r_eid   <= 5'd0;
            r_elast <= 1'b1;
        end
        // saturate distances beyond the top level
        if (i_cmd.pl0) begin
            if ((exp_gap >> TOP) != 32'd0) begin
                r_dist <= TOP_MAX;
                r_exp  <= r_tick + TOP_MAX;
            end else begin
                r_dist <= exp_gap;
            end
        end
        if (i_cmd.pl1) r_bkt <= pl_bkt;
        if (i_cmd.emit && out_free) begin
            r_okind <= r_kind;
            r_oid   <= r_eid;
            r_otick <= r_tick;
            r_olast <= r_elast;
        end
    end

    assign i_req.ready        = i_cmd.latch;
    assign o_evt.valid        = r_ov;
    assign o_evt.event_kind   = r_okind;
    assign o_evt.timer_id_out = r_oid;
    assign o_evt.tick_value   = r_otick;
    assign o_evt.last         = r_olast;

    always_comb begin
        o_sts.clr_done  = r_clr == BW'(NBK - 1);
        o_sts.in_valid  = i_req.valid;
        o_sts.req_type  = r_type;
        o_sts.req_bad   = (r_type == hwt_pkg::REQ_ADD) ? add_bad : kill_bad;
        o_sts.near_zero = r_tick[NEAR_BITS-1:0] == '0;
        o_sts.head_ok   = head_q < LW'(NUM_TIMERS);
        o_sts.nx_ok     = r_nx < LW'(NUM_TIMERS);
        o_sts.lvl_end   = (r_lvl == 2'd3) || (cas_idx[r_lvl] != '0);
        o_sts.killed    = r_killed[slot_ix];
        o_sts.per_nz    = r_pnz;
        o_sts.out_free  = out_free;
    end
endmodule

[rtl/hierarchical_timer_wheel_top.sv]
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_top
// Five-level timing wheel over a pool of timer slots.
// ----------------------------------------------------------------------------
// Usage:
//  - i_req carries add, kill and tick requests; o_evt carries events, the
//    last one of each request flagged with last. Code 3 requests are dropped.
//  - Add and kill give one event. A tick gives one expired event per live
//    timer in the due near bucket, then tick done.
//  - One request at a time. A tick expires and re-arms timers and frees
//    killed ones, and, when the low counter bits wrap, first cascades
//    timers level by level. The bucket walks go through memories with one
//    registered read port each.
//  - Events sit in an output register; the next request is taken while an
//    event waits. A stalled receiver holds the sequencer at its next event.
//  - After reset the bucket head memory is cleared, one entry a cycle, all
//    2^NEAR_BITS + 4*2^LEVEL_BITS entries (512 by default), with i_req.ready
//    low throughout. Counter, alive and kill flags clear at once.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_top #(
    parameter int NUM_TIMERS = hwt_pkg::NUM_TIMERS_DEF,
    parameter int NEAR_BITS  = hwt_pkg::NEAR_BITS_DEF,
    parameter int LEVEL_BITS = hwt_pkg::LEVEL_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hwt_req_if.sink   i_req,
    hwt_evt_if.source o_evt
);
    hwt_pkg::t_cmd cmd;
    hwt_pkg::t_sts sts;

    // sequencer
    hwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // memories, flags and event register
    hwt_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .NEAR_BITS  (NEAR_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_evt   (o_evt),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hierarchical_timer_wheel_top: a timer wheel model
// predicts the events of every accepted request, and each event leaving the
// block is compared in order with the oldest prediction. Random idling on
// both channels, a long receiver hold-off and a drain pause stress the
// handshakes.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS    = hwt_pkg::NUM_TIMERS_DEF;
    localparam int NBITS    = hwt_pkg::NEAR_BITS_DEF;
    localparam int LBITS    = hwt_pkg::LEVEL_BITS_DEF;
    localparam int NSIZE    = 1 << NBITS;
    localparam int LSIZE    = 1 << LBITS;
    localparam int NBUCKETS = NSIZE + 4 * LSIZE;
    localparam int TOPBITS  = NBITS + 4 * LBITS;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] REQ_UNUSED = 2'd3;   // dropped by the block

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  id;
        logic [31:0] delay;
        logic [31:0] period;
    } t_request;

    typedef struct {
        logic [2:0]  kind;
        logic [4:0]  id;
        logic [31:0] tick;
        logic        last;
    } t_event;

    // ------------------------------------------------------------------------
    // Timer wheel model and event scoreboard
    // ------------------------------------------------------------------------
    class wheel_scoreboard;
        logic [31:0] now_tick;
        logic [31:0] expiry [SLOTS];
        logic [31:0] period [SLOTS];
        bit          alive  [SLOTS];
        bit          killed [SLOTS];
        logic [5:0]  next_slot [SLOTS];
        logic [5:0]  head [NBUCKETS];
        logic [5:0]  tail [NBUCKETS];
        t_event      pending_events [$];
        int          mismatches;

        function void clear();
            now_tick = '0;
            mismatches = 0;
            for (int i = 0; i < SLOTS; i++) begin
                alive[i] = 0;
                killed[i] = 0;
                next_slot[i] = hwt_pkg::EMPTY_MARK;
            end
            for (int i = 0; i < NBUCKETS; i++) begin
                head[i] = hwt_pkg::EMPTY_MARK;
                tail[i] = hwt_pkg::EMPTY_MARK;
            end
        endfunction

        function void append(int b, int s);
            next_slot[s] = hwt_pkg::EMPTY_MARK;
            if (head[b] == hwt_pkg::EMPTY_MARK)
                head[b] = s[5:0];
            else if (tail[b] < SLOTS)
                next_slot[tail[b]] = s[5:0];
            tail[b] = s[5:0];
        endfunction

        // choose the bucket by distance to expiry
        function void file_timer(int s);
            logic [31:0] gap;
            longint unsigned lim;
            logic [63:0] ex;
            int b;
            gap = expiry[s] - now_tick;
            b = 0;
            if (TOPBITS < 32 && longint'(gap) >= (longint'(1) << TOPBITS)) begin
                gap = 32'((longint'(1) << TOPBITS) - 1);
                expiry[s] = now_tick + gap;
            end
            ex = {32'd0, expiry[s]};
            if (gap < NSIZE) begin
                b = int'(expiry[s] & (NSIZE - 1));
            end else begin
                for (int n = 0; n < 4; n++) begin
                    lim = longint'(1) << (NBITS + (n + 1) * LBITS);
                    if (longint'(gap) < lim || n == 3) begin
                        b = NSIZE + n * LSIZE
                            + int'((ex >> (NBITS + n * LBITS)) & (LSIZE - 1));
                        break;
                    end
                end
            end
            append(b, s);
        endfunction

        function void push(logic [2:0] k, logic [4:0] id, logic [31:0] t, logic l);
            t_event e;
            e.kind = k;
            e.id = id;
            e.tick = t;
            e.last = l;
            pending_events.push_back(e);
        endfunction

        function void note_request(t_request r);
            logic [31:0] t;
            int s, nx, idx, near_idx;
            case (r.kind)
                hwt_pkg::REQ_ADD: begin
                    if (r.id >= SLOTS || alive[r.id]) begin
                        push(hwt_pkg::EVT_ADD_BUSY, r.id, now_tick, 1'b1);
                    end else begin
                        expiry[r.id] = now_tick + (r.delay != 0 ? r.delay : r.period);
                        period[r.id] = r.period;
                        alive[r.id] = 1;
                        killed[r.id] = 0;
                        file_timer(r.id);
                        push(hwt_pkg::EVT_ADD_OK, r.id, now_tick, 1'b1);
                    end
                end
                hwt_pkg::REQ_KILL: begin
                    if (r.id >= SLOTS || !alive[r.id] || killed[r.id]) begin
                        push(hwt_pkg::EVT_KILL_NA, r.id, now_tick, 1'b1);
                    end else begin
                        killed[r.id] = 1;
                        push(hwt_pkg::EVT_KILL_OK, r.id, now_tick, 1'b1);
                    end
                end
                hwt_pkg::REQ_TICK: begin
                    t = now_tick;
                    near_idx = int'(t & (NSIZE - 1));
                    // cascade coarser levels when the near wheel wraps
                    if (near_idx == 0) begin
                        for (int n = 0; n < 4; n++) begin
                            idx = int'(({32'd0, t} >> (NBITS + n * LBITS)) & (LSIZE - 1));
                            s = head[NSIZE + n * LSIZE + idx];
                            head[NSIZE + n * LSIZE + idx] = hwt_pkg::EMPTY_MARK;
                            while (s < SLOTS) begin
                                nx = next_slot[s];
                                file_timer(s);
                                s = nx;
                            end
                            if (idx != 0)
                                break;
                        end
                    end
                    now_tick = t + 1;
                    s = head[near_idx];
                    head[near_idx] = hwt_pkg::EMPTY_MARK;
                    while (s < SLOTS) begin
                        nx = next_slot[s];
                        if (killed[s]) begin
                            alive[s] = 0;
                            killed[s] = 0;
                        end else begin
                            push(hwt_pkg::EVT_EXPIRED, s[4:0], now_tick, 1'b0);
                            if (period[s] != 0) begin
                                expiry[s] = t + period[s];
                                file_timer(s);
                            end else begin
                                alive[s] = 0;
                            end
                        end
                        s = nx;
                    end
                    push(hwt_pkg::EVT_TICK_DONE, 5'd0, now_tick, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_event(t_event got);
            t_event want;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d id %0d tick %0d last %0d",
                             got.kind, got.id, got.tick, got.last);
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind || got.id !== want.id ||
                got.tick !== want.tick || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("event mismatch: expected kind %0d id %0d tick %0d last %0d,",
                             want.kind, want.id, want.tick, want.last,
                             " got kind %0d id %0d tick %0d last %0d",
                             got.kind, got.id, got.tick, got.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    hwt_req_if req_ch ();
    hwt_evt_if evt_ch ();

    hierarchical_timer_wheel_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_evt  (evt_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    wheel_scoreboard sb;
    int send_idle_pct;     // sender idle chance per cycle
    int recv_stall_pct;    // receiver stall chance per cycle
    int hold_asked;        // bumped by the sender side to request a long hold-off
    int hold_taken;
    int hold_left;
    int quiet_cycles;

    // ------------------------------------------------------------------------
    // Event sink: checks on handshake, then picks ready for the next cycle.
    // A long hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_event got;
        if (i_rst_n && evt_ch.valid && evt_ch.ready) begin
            got.kind = evt_ch.event_kind;
            got.id = evt_ch.timer_id_out;
            got.tick = evt_ch.tick_value;
            got.last = evt_ch.last;
            sb.check_event(got);
        end
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            evt_ch.ready <= 1'b0;
        end else begin
            evt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles without any handshake on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("hierarchical_timer_wheel_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    task automatic send_request(logic [1:0] kind, logic [4:0] id,
                                logic [31:0] delay, logic [31:0] period);
        t_request r;
        r.kind = kind;
        r.id = id;
        r.delay = delay;
        r.period = period;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.timer_id <= id;
        req_ch.delay    <= delay;
        req_ch.period   <= period;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(r);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_events.size() != 0)
            @(posedge i_clk);
    endtask

    // random request, biased toward timers that fire within the run
    task automatic send_random();
        int pick;
        logic [31:0] d, p;
        pick = $urandom_range(99);
        d = $urandom_range(1, 40);
        p = '0;
        case ($urandom_range(9))
            0: d = $urandom();
            1: d = '0;
            2: d = $urandom_range(200, 600);
            default: ;
        endcase
        case ($urandom_range(5))
            0: p = $urandom_range(1, 30);
            1: p = $urandom();
            2: p = $urandom_range(1, 8);
            default: ;
        endcase
        if (d == 0 && p == 0 && $urandom_range(1))
            p = $urandom_range(1, 20);
        if (pick < 35)
            send_request(hwt_pkg::REQ_ADD, 5'($urandom()), d, p);
        else if (pick < 52)
            send_request(hwt_pkg::REQ_KILL, 5'($urandom()), $urandom(), $urandom());
        else if (pick < 97)
            send_request(hwt_pkg::REQ_TICK, 5'($urandom()), $urandom(), $urandom());
        else
            send_request(REQ_UNUSED, 5'($urandom()), $urandom(), $urandom());
    endtask

    initial begin
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_asked = 0;
        hold_taken = 0;
        hold_left = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = hwt_pkg::REQ_ADD;
        req_ch.timer_id = '0;
        req_ch.delay = '0;
        req_ch.period = '0;
        evt_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: busy/idle slots, periodic, zero delay, extremes, code 3
        send_request(hwt_pkg::REQ_ADD, 5'd0, 32'd1, 32'd0);
        send_request(hwt_pkg::REQ_ADD, 5'd0, 32'd5, 32'd0);
        send_request(hwt_pkg::REQ_ADD, 5'd1, 32'd0, 32'd2);
        send_request(hwt_pkg::REQ_ADD, 5'd2, 32'd3, 32'd0);
        send_request(hwt_pkg::REQ_KILL, 5'd2, 32'd0, 32'd0);
        send_request(hwt_pkg::REQ_KILL, 5'd2, 32'd0, 32'd0);
        send_request(hwt_pkg::REQ_ADD, 5'd2, 32'd4, 32'd0);
        send_request(hwt_pkg::REQ_KILL, 5'd5, 32'hffff_ffff, 32'hffff_ffff);
        send_request(hwt_pkg::REQ_ADD, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
        send_request(hwt_pkg::REQ_ADD, 5'd4, 32'd300, 32'd0);
        send_request(hwt_pkg::REQ_ADD, 5'd6, 32'd0, 32'd0);
        send_request(hwt_pkg::REQ_ADD, 5'd7, 32'd2, 32'd1);
        send_request(REQ_UNUSED, 5'd9, 32'd1, 32'd1);
        repeat (6) send_request(hwt_pkg::REQ_TICK, 5'd0, 32'd0, 32'd0);
        send_request(hwt_pkg::REQ_ADD, 5'd2, 32'd1, 32'd0);
        send_request(hwt_pkg::REQ_KILL, 5'd7, 32'd0, 32'd0);
        send_request(hwt_pkg::REQ_KILL, 5'd1, 32'd0, 32'd0);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 33 : 0;
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 33 : 0;
            for (int i = 0; i < 60; i++) begin
                if (ph == 0 && i == 10)
                    hold_asked++;   // block backs up behind a stalled receiver
                if (ph == 2 && i == 30)
                    wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("hierarchical_timer_wheel_top test passed");
        else
            $display("hierarchical_timer_wheel_top test failed");
        $finish;
    end

endmodule

[hierarchical_timer_wheel_top.f]
rtl/hwt_pkg.sv
rtl/hwt_req_if.sv
rtl/hwt_evt_if.sv
rtl/hwt_ram.sv
rtl/hwt_ctrl.sv
rtl/hwt_datapath.sv
rtl/hierarchical_timer_wheel_top.sv
tb/tb.sv
